>>> rtl/ccw_pkg.sv
// Shared constants for the chunk container walker.
// Walk phases, status codes, register indexes and the mask chunk GUID.
// No dependencies.
package ccw_pkg;

	localparam int unsigned HEADER_BYTES = 20;
	localparam int unsigned MIN_LEFT     = 21;

	// walk phase
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// result status
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_CORRUPT_SIZE = 2'd1;
	localparam logic [1:0] ST_TOO_SHORT    = 2'd2;
	localparam logic [1:0] ST_NO_CONTAINER = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CONTAINER_PRESENT = 2'd0;
	localparam logic [1:0] CFG_TOTAL_LENGTH      = 2'd1;
	localparam logic [1:0] CFG_STOP_ON_MASK      = 2'd2;

	// valid-pixel-mask chunk GUID, as stored little-endian
	localparam logic [63:0] MASK_ID_LOW  = 64'h492B_5BFC_CBE3_EA67;
	localparam logic [63:0] MASK_ID_HIGH = 64'h4814_0378_E3EC_6AA1;

endpackage

>>> rtl/chunk_container_walker.sv
// Chunk container walker: parses GUID/size chunk headers one byte per word.
// Depends on ccw_pkg for phase, status, register codes and the mask GUID.
// A header's last byte gives its record through the input register, then the result register.
// Throughput: one byte per cycle while no record is held back by out_stall,
// set by the single header-decode step between the two registers.
// Reset (arst_n low, asynchronous): walk restarts at chunk 0; config, walk-state and out_valid registers reset.
module chunk_container_walker
	import ccw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// byte stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// chunk records
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] chunk_number,
	output logic [63:0] id_low,
	output logic [63:0] id_high,
	output logic [31:0] payload_length,
	output logic [31:0] payload_start,
	output logic        mask_match,
	output logic [1:0]  status,
	output logic        final_res
);

	localparam logic [4:0]  LAST_HDR = 5'(HEADER_BYTES - 1);
	localparam logic [32:0] HDR_ADD  = 33'(HEADER_BYTES);
	localparam logic [31:0] MIN_L32  = 32'(MIN_LEFT);

	// configuration registers
	logic        container_present_q;
	logic [31:0] total_length_q;
	logic        stop_on_mask_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// walk state
	logic [1:0]  phase_q;
	logic [4:0]  hdr_count_q;
	logic [63:0] id_low_q;
	logic [63:0] id_high_q;
	logic [23:0] len_low_q;
	logic [31:0] payload_left_q;
	logic [31:0] chunk_base_q;
	logic [32:0] start_q;
	logic [31:0] chunk_count_q;

	// result register
	logic        out_valid_q;
	logic [31:0] chunk_number_q;
	logic [63:0] id_low_r_q;
	logic [63:0] id_high_r_q;
	logic [31:0] payload_length_q;
	logic [31:0] payload_start_q;
	logic        mask_match_q;
	logic [1:0]  status_q;
	logic        final_q;

	// decode
	logic        first_byte;
	logic        start_fail;
	logic        hdr_done;
	logic        emit;
	logic        advance;
	logic        out_free;
	logic [31:0] len_full;
	logic [33:0] end_sum;
	logic        corrupt;
	logic        near_end;
	logic        id_match;
	logic        fin;
	logic [1:0]  fail_status;

	assign out_free   = !out_valid_q || !out_stall;
	assign first_byte = (hdr_count_q == '0) && (chunk_count_q == '0) && (chunk_base_q == '0);
	assign start_fail = first_byte && (!container_present_q || (total_length_q < MIN_L32));
	assign fail_status = !container_present_q ? ST_NO_CONTAINER : ST_TOO_SHORT;
	assign hdr_done   = (hdr_count_q == LAST_HDR);
	assign emit       = (phase_q == PH_HEADER) && (start_fail || hdr_done);
	assign advance    = valid_s1 && (!emit || out_free);
	assign in_stall   = valid_s1 && !advance;

	assign len_full = {byte_s1, len_low_q};
	assign end_sum  = {1'b0, start_q} + {2'b00, len_full};
	assign corrupt  = end_sum > {2'b00, total_length_q};
	// end + 21 > total, without a second adder behind end_sum
	assign near_end = (total_length_q < MIN_L32) ||
		(end_sum > {2'b00, total_length_q - MIN_L32});
	assign id_match = (id_low_q == MASK_ID_LOW) && (id_high_q == MASK_ID_HIGH);
	assign fin      = (stop_on_mask_q && id_match) || near_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			container_present_q <= 1'b0;
			total_length_q      <= '0;
			stop_on_mask_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONTAINER_PRESENT: container_present_q <= cfg_data[0];
				CFG_TOTAL_LENGTH:      total_length_q      <= cfg_data;
				CFG_STOP_ON_MASK:      stop_on_mask_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// payload offset of the current chunk; base holds for the whole header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= HDR_ADD;
		end else begin
			start_q <= {1'b0, chunk_base_q} + HDR_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			hdr_count_q    <= '0;
			payload_left_q <= '0;
			chunk_base_q   <= '0;
			chunk_count_q  <= '0;
			id_low_q       <= '0;
			id_high_q      <= '0;
			len_low_q      <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_PAYLOAD: begin
					payload_left_q <= payload_left_q - 32'd1;
					if (payload_left_q == 32'd1) begin
						phase_q <= PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (start_fail) begin
						phase_q <= PH_DONE;
					end else if (hdr_done) begin
						hdr_count_q <= '0;
						if (corrupt) begin
							phase_q <= PH_DONE;
						end else begin
							chunk_count_q <= chunk_count_q + 32'd1;
							chunk_base_q  <= end_sum[31:0];
							if (fin) begin
								phase_q <= PH_DONE;
							end else if (len_full != '0) begin
								payload_left_q <= len_full;
								phase_q        <= PH_PAYLOAD;
							end
						end
					end else begin
						hdr_count_q <= hdr_count_q + 5'd1;
						// place the byte; every byte is rewritten before use
						if (hdr_count_q[4]) begin
							len_low_q[{hdr_count_q[1:0], 3'b000} +: 8] <= byte_s1;
						end else if (hdr_count_q[3]) begin
							id_high_q[{hdr_count_q[2:0], 3'b000} +: 8] <= byte_s1;
						end else begin
							id_low_q[{hdr_count_q[2:0], 3'b000} +: 8] <= byte_s1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (start_fail) begin
				chunk_number_q   <= '0;
				id_low_r_q       <= '0;
				id_high_r_q      <= '0;
				payload_length_q <= '0;
				payload_start_q  <= '0;
				mask_match_q     <= 1'b0;
				status_q         <= fail_status;
				final_q          <= 1'b1;
			end else begin
				chunk_number_q   <= chunk_count_q;
				id_low_r_q       <= id_low_q;
				id_high_r_q      <= id_high_q;
				payload_length_q <= len_full;
				payload_start_q  <= start_q[31:0];
				mask_match_q     <= !corrupt && id_match;
				status_q         <= corrupt ? ST_CORRUPT_SIZE : ST_OK;
				final_q          <= corrupt || fin;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign chunk_number   = chunk_number_q;
	assign id_low         = id_low_r_q;
	assign id_high        = id_high_r_q;
	assign payload_length = payload_length_q;
	assign payload_start  = payload_start_q;
	assign mask_match     = mask_match_q;
	assign status         = status_q;
	assign final_res      = final_q;

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("walk left the done phase");

	a_final_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && (start_fail || corrupt || fin)) |=> phase_q == PH_DONE)
		else $error("final record did not end the walk");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> final_q)
		else $error("error record not marked final");

	a_hdr_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_count_q <= LAST_HDR)
		else $error("header byte count out of range");

endmodule

>>> dv/chunk_container_walker_test.sv
`timescale 1ns / 100ps
// Self-checking bench for chunk_container_walker: feeds chunk container bytes and
// checks each chunk record against an in-bench model of the walk.
// Depends on ccw_pkg and the chunk_container_walker RTL.
module chunk_container_walker_test;
	import ccw_pkg::*;

	localparam int unsigned BYTE_TARGET  = 1650;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned QUIET_FROM   = 1200;
	localparam int unsigned QUIET_TO     = 1800;
	localparam int unsigned DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [31:0] chunk_no;
		logic [63:0] guid_lo;
		logic [63:0] guid_hi;
		logic [31:0] payload_len;
		logic [31:0] payload_at;
		logic        is_mask;
		logic [1:0]  status;
		logic        ends_walk;
	} chunk_rec_t;

	typedef enum {END_HUGE_SIZE, END_SIZE_OVER_BY_ONE, END_SHORT_TAIL, END_MASK_STOP} walk_end_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_CONTAINER_PRESENT;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] chunk_number;
	logic [63:0] id_low;
	logic [63:0] id_high;
	logic [31:0] payload_length;
	logic [31:0] payload_start;
	logic        mask_match;
	logic [1:0]  status;
	logic        final_res;

	chunk_container_walker i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.chunk_number   (chunk_number),
		.id_low         (id_low),
		.id_high        (id_high),
		.payload_length (payload_length),
		.payload_start  (payload_start),
		.mask_match     (mask_match),
		.status         (status),
		.final_res      (final_res)
	);

	// register copies seen by the walk model
	logic        reg_container = 1'b0;
	logic [31:0] reg_total = '0;
	logic        reg_stop = 1'b0;

	// walk model state
	logic [1:0]  walk_phase = PH_HEADER;
	logic [4:0]  hdr_count = '0;
	logic [63:0] guid_lo_acc = '0;
	logic [63:0] guid_hi_acc = '0;
	logic [31:0] size_acc = '0;
	logic [31:0] left_bytes = '0;
	logic [31:0] chunk_base_pos = '0;
	logic [31:0] chunk_idx = '0;

	logic [7:0]      pending_bytes[$];
	chunk_rec_t      pending_records[$];
	longint unsigned layout_pos = 0;
	int unsigned     bytes_queued = 0;
	int unsigned     bytes_accepted = 0;
	int unsigned     records_checked = 0;
	int unsigned     mask_records = 0;
	int unsigned     mismatches = 0;
	int unsigned     cycle_count = 0;
	logic [1:0]      last_status = ST_OK;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d records still awaited", $time, pending_records.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic bit take_break();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 30;
	endfunction

	// Advance the walk by one accepted word and queue the record it yields.
	task automatic walk_byte(input logic [7:0] b);
		logic [33:0] start_pos;
		logic [33:0] end_pos;
		chunk_rec_t  rec;
		rec = '0;
		if (walk_phase == PH_DONE)
			return;
		if (walk_phase == PH_PAYLOAD) begin
			left_bytes = left_bytes - 1;
			if (left_bytes == 0)
				walk_phase = PH_HEADER;
			return;
		end
		if (hdr_count == 0 && chunk_idx == 0 && chunk_base_pos == 0) begin
			if (!reg_container || reg_total < MIN_LEFT) begin
				rec.status = reg_container ? ST_TOO_SHORT : ST_NO_CONTAINER;
				rec.ends_walk = 1'b1;
				walk_phase = PH_DONE;
				pending_records.push_back(rec);
				return;
			end
		end
		if (hdr_count == 0) begin
			guid_lo_acc = '0;
			guid_hi_acc = '0;
			size_acc = '0;
		end
		if (hdr_count < 8)
			guid_lo_acc[8*hdr_count +: 8] = b;
		else if (hdr_count < 16)
			guid_hi_acc[8*(hdr_count-8) +: 8] = b;
		else
			size_acc[8*(hdr_count-16) +: 8] = b;
		hdr_count = hdr_count + 5'd1;
		if (hdr_count < HEADER_BYTES)
			return;
		hdr_count = '0;

		// 34-bit sums so a huge size cannot wrap past the total
		start_pos = chunk_base_pos + HEADER_BYTES;
		end_pos = start_pos + size_acc;
		rec.chunk_no = chunk_idx;
		rec.guid_lo = guid_lo_acc;
		rec.guid_hi = guid_hi_acc;
		rec.payload_len = size_acc;
		rec.payload_at = start_pos[31:0];
		if (end_pos > reg_total) begin
			rec.status = ST_CORRUPT_SIZE;
			rec.ends_walk = 1'b1;
			walk_phase = PH_DONE;
			pending_records.push_back(rec);
			return;
		end
		rec.is_mask = (guid_lo_acc == MASK_ID_LOW && guid_hi_acc == MASK_ID_HIGH);
		rec.status = ST_OK;
		rec.ends_walk = (reg_stop && rec.is_mask) || (end_pos + MIN_LEFT > reg_total);
		pending_records.push_back(rec);
		chunk_idx = chunk_idx + 1;
		chunk_base_pos = end_pos[31:0];
		if (rec.ends_walk) begin
			walk_phase = PH_DONE;
		end else if (size_acc != 0) begin
			left_bytes = size_acc;
			walk_phase = PH_PAYLOAD;
		end else begin
			walk_phase = PH_HEADER;
		end
	endtask

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				walk_byte(data_byte);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (pending_bytes.size() != 0 && !take_break()) begin
				in_valid <= 1'b1;
				data_byte <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// record monitor
	always @(posedge clk) begin : record_check
		chunk_rec_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_records.size() == 0) begin
					$display("%0t: record for chunk %0d with status %0d expected none",
						$time, chunk_number, status);
					mismatches++;
				end else begin
					want = pending_records.pop_front();
					check_field("chunk_number", want.chunk_no, chunk_number);
					check_field("id_low", want.guid_lo, id_low);
					check_field("id_high", want.guid_hi, id_high);
					check_field("payload_length", want.payload_len, payload_length);
					check_field("payload_start", want.payload_at, payload_start);
					check_field("mask_match", want.is_mask, mask_match);
					check_field("status", want.status, status);
					check_field("final_res", want.ends_walk, final_res);
					records_checked++;
					if (want.is_mask)
						mask_records++;
					last_status = want.status;
				end
			end
			out_stall <= take_break();
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CONTAINER_PRESENT: reg_container = value[0];
			CFG_TOTAL_LENGTH:      reg_total = value;
			CFG_STOP_ON_MASK:      reg_stop = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Wait until every word is taken, every record is in, and the pipe is empty.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || pending_records.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_header(input logic [63:0] lo, input logic [63:0] hi, input logic [31:0] len);
		for (int i = 0; i < 8; i++)
			pending_bytes.push_back(lo[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			pending_bytes.push_back(hi[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			pending_bytes.push_back(len[8*i +: 8]);
		bytes_queued += HEADER_BYTES;
		layout_pos += HEADER_BYTES + len;
	endtask

	task automatic push_payload(input int unsigned count);
		repeat (count)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
		bytes_queued += count;
	endtask

	task automatic pick_id(input bit allow_mask, output logic [63:0] lo, output logic [63:0] hi);
		int unsigned roll;
		int unsigned pos;
		roll = $urandom_range(0, 99);
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		if (roll < 15 && allow_mask) begin
			lo = MASK_ID_LOW;
			hi = MASK_ID_HIGH;
		end else if (roll >= 15 && roll < 30) begin
			// near miss: mask GUID with one bit flipped
			lo = MASK_ID_LOW;
			hi = MASK_ID_HIGH;
			pos = $urandom_range(0, 127);
			if (pos < 64)
				lo[pos] = ~lo[pos];
			else
				hi[pos-64] = ~hi[pos-64];
		end else if (roll >= 30 && roll < 35) begin
			{lo, hi} = '0;
		end else if (roll >= 35 && roll < 40) begin
			{lo, hi} = '1;
		end
	endtask

	function automatic logic [31:0] pick_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return '0;
		if (roll < 85)
			return $urandom_range(1, 16);
		return $urandom_range(17, 48);
	endfunction

	initial begin : stimulus
		walk_end_t   ending;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [31:0] len;
		logic [31:0] len2;
		int unsigned spare;
		int unsigned chunks_left;
		bit          stop_armed;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		if ($urandom_range(0, 9) < 2) begin
			// walk refused at the first word: no container, or too short
			cfg_write(CFG_STOP_ON_MASK, $urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				cfg_write(CFG_CONTAINER_PRESENT, 32'd0);
				cfg_write(CFG_TOTAL_LENGTH, $urandom);
			end else begin
				cfg_write(CFG_CONTAINER_PRESENT, 32'd1);
				case ($urandom_range(0, 2))
					0:       cfg_write(CFG_TOTAL_LENGTH, '0);
					1:       cfg_write(CFG_TOTAL_LENGTH, MIN_LEFT - 1);
					default: cfg_write(CFG_TOTAL_LENGTH, $urandom_range(1, MIN_LEFT - 2));
				endcase
			end
			// every word after the refusal must be dropped
			push_payload(BYTE_TARGET);
		end else begin
			cfg_write(CFG_CONTAINER_PRESENT, 32'd1);
			cfg_write(CFG_STOP_ON_MASK, 32'd0);
			cfg_write(CFG_TOTAL_LENGTH, 32'hFFFF_FFFF);

			// mask chunk carrying both byte extremes as payload
			push_header(MASK_ID_LOW, MASK_ID_HIGH, 32'd2);
			pending_bytes.push_back(8'h00);
			pending_bytes.push_back(8'hFF);
			bytes_queued += 2;

			stop_armed = 1'b0;
			while (bytes_queued < BYTE_TARGET) begin
				chunks_left = $urandom_range(6, 20);
				while (chunks_left != 0 && bytes_queued < BYTE_TARGET) begin
					pick_id(!stop_armed, lo, hi);
					len = pick_size();
					push_header(lo, hi, len);
					push_payload(len);
					chunks_left--;
				end
				settle();
				// change registers mid-walk; the walk must carry on
				stop_armed = 1'($urandom_range(0, 1));
				cfg_write(CFG_STOP_ON_MASK, 32'(stop_armed));
				cfg_write(CFG_CONTAINER_PRESENT, $urandom_range(0, 1));
				case ($urandom_range(0, 2))
					0:       cfg_write(CFG_TOTAL_LENGTH, 32'hFFFF_FFFF);
					1:       cfg_write(CFG_TOTAL_LENGTH, 32'h8000_0000 + $urandom_range(0, 4095));
					default: cfg_write(CFG_TOTAL_LENGTH,
						32'(layout_pos + 3000 + $urandom_range(0, 5000)));
				endcase
			end

			settle();
			ending = walk_end_t'($urandom_range(0, 3));
			case (ending)
				END_HUGE_SIZE: begin
					cfg_write(CFG_TOTAL_LENGTH, 32'hFFFF_FFFF);
					pick_id(1'b1, lo, hi);
					push_header(lo, hi, 32'hFFFF_FFFF);
				end
				END_SIZE_OVER_BY_ONE: begin
					len = $urandom_range(1, 30);
					cfg_write(CFG_TOTAL_LENGTH, 32'(layout_pos + HEADER_BYTES + len - 1));
					pick_id(1'b1, lo, hi);
					push_header(lo, hi, len);
				end
				END_SHORT_TAIL: begin
					// second chunk ends with fewer than MIN_LEFT bytes left, possibly none
					len = $urandom_range(0, 12);
					len2 = $urandom_range(0, 8);
					spare = $urandom_range(0, MIN_LEFT - 1);
					if (len2 + spare == 0)
						spare = 1;
					cfg_write(CFG_TOTAL_LENGTH,
						32'(layout_pos + 2 * HEADER_BYTES + len + len2 + spare));
					pick_id(!stop_armed, lo, hi);
					push_header(lo, hi, len);
					push_payload(len);
					pick_id(!stop_armed, lo, hi);
					push_header(lo, hi, len2);
					push_payload(len2);
				end
				default: begin
					cfg_write(CFG_STOP_ON_MASK, 32'd1);
					repeat ($urandom_range(0, 3)) begin
						pick_id(1'b0, lo, hi);
						len = pick_size();
						push_header(lo, hi, len);
						push_payload(len);
					end
					len = $urandom_range(0, 8);
					push_header(MASK_ID_LOW, MASK_ID_HIGH, len);
					push_payload(len);
				end
			endcase
			// the walk is over: these words must be dropped
			push_payload(16);
		end

		settle();
		$display("walked %0d bytes in %0d cycles, checked %0d chunk records (%0d mask chunks)",
			bytes_accepted, cycle_count, records_checked, mask_records);
		$display("walk closed with status %0d", last_status);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
